@@ sv/ssr_pkg.sv @@
// Shared constants, codes and types of the substring replace block.
package ssr_pkg;

    // Capacity of each byte store and the widths that follow from it.
    localparam int MAX_LEN = 128;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // Stream widths.
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;

    // Command codes carried in the input tuser field.
    typedef enum logic [2:0] {
        CMD_APPEND_WORD = 3'd0,
        CMD_APPEND_PAT  = 3'd1,
        CMD_APPEND_REP  = 3'd2,
        CMD_CLEAR_PR    = 3'd3,
        CMD_CLEAR_WORD  = 3'd4,
        CMD_RUN         = 3'd5,
        CMD_READ        = 3'd6,
        CMD_NOP         = 3'd7
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // One request to a byte store: a write port and a read address.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

@@ sv/ssr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ssr_ctrl.sv @@
// Command sequencer: loads, reads and the find-and-replace walk over the stores.
module ssr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [ssr_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [ssr_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [ssr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output ssr_pkg::t_ram_req               o_word_req,
    output ssr_pkg::t_ram_req               o_pat_req,
    output ssr_pkg::t_ram_req               o_rep_req,
    input  logic [7:0]                      i_word_rdata,
    input  logic [7:0]                      i_pat_rdata,
    input  logic [7:0]                      i_rep_rdata
);
    import ssr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_FIND_RD,
        S_FIND_CHK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_REP_RD,
        S_REP_WR,
        S_NEXT
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_wlen, n_wlen;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [LEN_W-1:0] r_rlen, n_rlen;
    logic [LEN_W-1:0] r_i, n_i;
    logic [LEN_W-1:0] r_j, n_j;
    logic [LEN_W-1:0] r_k, n_k;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic             r_rd_ok, n_rd_ok;
    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [7:0]       r_rbyte, n_rbyte;

    t_cmd             cmd;
    logic [7:0]       in_byte;
    logic [6:0]       in_idx;
    logic             accept;
    logic             move_up;
    logic [LEN_W-1:0] tail;

    assign cmd     = t_cmd'(i_s_axis_tuser);
    assign in_byte = i_s_axis_tdata[7:0];
    assign in_idx  = i_s_axis_tdata[14:8];

    // A new command enters only when idle and the result slot frees up.
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign move_up = r_rlen > r_plen;
    assign tail    = r_wlen - r_i - r_plen;

    // Result transaction: status, length after the command and read byte.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_rbyte, 8'(r_wlen), r_status};

    // Next-state logic for the whole sequencer.
    always_comb begin
        n_state     = r_state;
        n_wlen      = r_wlen;
        n_plen      = r_plen;
        n_rlen      = r_rlen;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_status    = r_status;
        n_rbyte     = r_rbyte;
        o_word_req  = '0;
        o_pat_req   = '0;
        o_rep_req   = '0;

        case (r_state)
            S_IDLE: begin
                // Reads are always issued at the index so the data is ready next cycle.
                o_word_req.raddr = ADDR_W'(in_idx);
                if (accept) begin
                    n_status = ST_OK;
                    n_rbyte  = 8'd0;
                    case (cmd)
                        CMD_APPEND_WORD: begin
                            n_out_valid = 1'b1;
                            if (r_wlen >= LEN_W'(MAX_LEN)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_word_req.we    = 1'b1;
                                o_word_req.waddr = ADDR_W'(r_wlen);
                                o_word_req.wdata = in_byte;
                                n_wlen           = r_wlen + 1'b1;
                            end
                        end
                        CMD_APPEND_PAT: begin
                            n_out_valid = 1'b1;
                            if (r_plen >= LEN_W'(MAX_LEN)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_pat_req.we    = 1'b1;
                                o_pat_req.waddr = ADDR_W'(r_plen);
                                o_pat_req.wdata = in_byte;
                                n_plen          = r_plen + 1'b1;
                            end
                        end
                        CMD_APPEND_REP: begin
                            n_out_valid = 1'b1;
                            if (r_rlen >= LEN_W'(MAX_LEN)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_rep_req.we    = 1'b1;
                                o_rep_req.waddr = ADDR_W'(r_rlen);
                                o_rep_req.wdata = in_byte;
                                n_rlen          = r_rlen + 1'b1;
                            end
                        end
                        CMD_CLEAR_PR: begin
                            n_out_valid = 1'b1;
                            n_plen      = '0;
                            n_rlen      = '0;
                        end
                        CMD_CLEAR_WORD: begin
                            n_out_valid = 1'b1;
                            n_wlen      = '0;
                        end
                        CMD_RUN: begin
                            if (r_plen == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_i     = '0;
                                n_j     = '0;
                                n_state = S_FIND_RD;
                            end
                        end
                        CMD_READ: begin
                            n_rd_ok = {{LEN_W{1'b0}}, in_idx} < {7'd0, r_wlen};
                            n_state = S_RD_WAIT;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_out_valid = 1'b1;
                n_rbyte     = r_rd_ok ? i_word_rdata : 8'd0;
                n_state     = S_IDLE;
            end
            S_FIND_RD: begin
                // Stop once the pattern no longer fits behind the search position.
                if (({1'b0, r_i} + {1'b0, r_plen}) > {1'b0, r_wlen}) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    o_word_req.raddr = ADDR_W'(r_i + r_j);
                    o_pat_req.raddr  = ADDR_W'(r_j);
                    n_state          = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (i_word_rdata != i_pat_rdata) begin
                    n_i     = r_i + 1'b1;
                    n_j     = '0;
                    n_state = S_FIND_RD;
                end else if (r_j + 1'b1 != r_plen) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_FIND_RD;
                end else if (({2'b00, r_wlen} + {2'b00, r_rlen}) >
                             ((LEN_W+2)'(MAX_LEN) + {2'b00, r_plen})) begin
                    // The replacement would not fit: keep the word as it is.
                    n_out_valid = 1'b1;
                    n_status    = ST_OVERFLOW;
                    n_state     = S_IDLE;
                end else begin
                    n_pos = r_i;
                    if (tail != '0 && r_rlen != r_plen) begin
                        n_cnt   = tail;
                        n_k     = move_up ? tail - 1'b1 : '0;
                        n_state = S_MOVE_RD;
                    end else begin
                        n_k     = '0;
                        n_state = (r_rlen != '0) ? S_REP_RD : S_NEXT;
                    end
                end
            end
            S_MOVE_RD: begin
                o_word_req.raddr = ADDR_W'(r_pos + r_plen + r_k);
                n_state          = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // Tail moves from the top when growing, from the bottom when shrinking.
                o_word_req.we    = 1'b1;
                o_word_req.waddr = ADDR_W'(r_pos + r_rlen + r_k);
                o_word_req.wdata = i_word_rdata;
                n_cnt            = r_cnt - 1'b1;
                if (r_cnt == LEN_W'(1)) begin
                    n_k     = '0;
                    n_state = (r_rlen != '0) ? S_REP_RD : S_NEXT;
                end else begin
                    n_k     = move_up ? r_k - 1'b1 : r_k + 1'b1;
                    n_state = S_MOVE_RD;
                end
            end
            S_REP_RD: begin
                o_rep_req.raddr = ADDR_W'(r_k);
                n_state         = S_REP_WR;
            end
            S_REP_WR: begin
                o_word_req.we    = 1'b1;
                o_word_req.waddr = ADDR_W'(r_pos + r_k);
                o_word_req.wdata = i_rep_rdata;
                n_k              = r_k + 1'b1;
                n_state          = (r_k + 1'b1 == r_rlen) ? S_NEXT : S_REP_RD;
            end
            S_NEXT: begin
                // Commit the new length and resume just past the inserted text.
                n_wlen  = r_wlen + r_rlen - r_plen;
                n_i     = r_pos + r_rlen;
                n_j     = '0;
                n_state = S_FIND_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, lengths, counters and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wlen      <= '0;
            r_plen      <= '0;
            r_rlen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wlen      <= n_wlen;
            r_plen      <= n_plen;
            r_rlen      <= n_rlen;
            r_out_valid <= n_out_valid;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_rd_ok  <= n_rd_ok;
        r_status <= n_status;
        r_rbyte  <= n_rbyte;
    end

endmodule

@@ sv/substring_replace_all.sv @@
// Loads, clears and unused codes answer in the cycle after the transaction; reads pass
// S_RD_WAIT first. A run uses a read state and a check or write state per compared, moved
// tail or inserted replacement byte, plus S_NEXT per replacement, all via one word RAM port
// pair. Loads and clears go one per cycle while results are taken; the rest one at a time.
// Reset clears the three lengths and the result slot; store contents stay undefined.
module substring_replace_all (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] byte_value, [14:8] read_index, [15] zero
    input  logic [ssr_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [2:0] command
    input  logic [ssr_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [1:0] status, [9:2] word_length_out, [17:10] read_byte, [23:18] zero
    output logic [ssr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import ssr_pkg::*;

    t_ram_req   word_req, pat_req, rep_req;
    logic [7:0] word_rdata, pat_rdata, rep_rdata;
    logic       s_accept;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Sequencer.
    ssr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_word_req      (word_req),
        .o_pat_req       (pat_req),
        .o_rep_req       (rep_req),
        .i_word_rdata    (word_rdata),
        .i_pat_rdata     (pat_rdata),
        .i_rep_rdata     (rep_rdata)
    );

    // Word buffer.
    ssr_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_req.we),
        .i_waddr (word_req.waddr),
        .i_wdata (word_req.wdata),
        .i_raddr (word_req.raddr),
        .o_rdata (word_rdata)
    );

    // Search pattern.
    ssr_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_req.we),
        .i_waddr (pat_req.waddr),
        .i_wdata (pat_req.wdata),
        .i_raddr (pat_req.raddr),
        .o_rdata (pat_rdata)
    );

    // Replacement text.
    ssr_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_rep_ram (
        .i_clk   (i_clk),
        .i_we    (rep_req.we),
        .i_waddr (rep_req.waddr),
        .i_wdata (rep_req.wdata),
        .i_raddr (rep_req.raddr),
        .o_rdata (rep_rdata)
    );

    // A read keeps the input closed while its RAM data is fetched.
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_axis_tuser == CMD_READ |=> !o_s_axis_tready)
        else $error("input accepted while a read is pending");

    // A read answers once S_RD_WAIT has registered its byte.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_axis_tuser == CMD_READ |=> ##1 o_m_axis_tvalid)
        else $error("read result missing");

    // A word append answers in the next cycle.
    a_append_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_axis_tuser == CMD_APPEND_WORD |=> o_m_axis_tvalid)
        else $error("append result missing");

    // The reported word length never exceeds the buffer capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[9:2] <= 8'(MAX_LEN))
        else $error("word length beyond capacity");

endmodule

@@ dv/substring_replace_all_checker.sv @@
// Checker for the substring replace block: predicts each result and compares it.
module substring_replace_all_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [ssr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [ssr_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [ssr_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                             o_errors,
    output int                             o_pending
);
    import ssr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Packed from the most significant end: read byte, word length, status.
    typedef struct packed {
        logic [7:0] rbyte;
        logic [7:0] wlen;
        t_status    status;
    } t_result;

    logic [7:0] word_mem [MAX_LEN];
    logic [7:0] pat_mem  [MAX_LEN];
    logic [7:0] rep_mem  [MAX_LEN];
    int word_count, pat_len, rep_len;
    int error_count = 0;
    t_result expected_results[$];

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Finds the pattern at or after start; returns -1 when absent.
    function automatic int find_pattern(input int start);
        int i, k;
        bit hit;
        if (pat_len == 0 || pat_len > word_count) return -1;
        for (i = start; i + pat_len <= word_count; i++) begin
            hit = 1;
            for (k = 0; k < pat_len; k++)
                if (word_mem[i+k] !== pat_mem[k]) hit = 0;
            if (hit) return i;
        end
        return -1;
    endfunction

    // Replaces every occurrence left to right, stopping on overflow.
    function automatic t_status replace_all();
        int pos, start, k, tail;
        logic [7:0] moved [MAX_LEN];
        start = 0;
        pos = find_pattern(start);
        while (pos >= 0) begin
            if (word_count + rep_len > MAX_LEN + pat_len) return ST_OVERFLOW;
            tail = word_count - pos - pat_len;
            for (k = 0; k < tail; k++) moved[k] = word_mem[pos+pat_len+k];
            for (k = 0; k < tail; k++) word_mem[pos+rep_len+k] = moved[k];
            for (k = 0; k < rep_len; k++) word_mem[pos+k] = rep_mem[k];
            word_count = word_count + rep_len - pat_len;
            start = pos + rep_len;
            pos = find_pattern(start);
        end
        return ST_OK;
    endfunction

    // Applies one command to the predicted state and returns its result.
    function automatic t_result predict_command(input t_cmd cmd, input logic [7:0] b,
                                                input logic [6:0] idx);
        t_result r;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_APPEND_WORD: begin
                if (word_count >= MAX_LEN) r.status = ST_FULL;
                else begin word_mem[word_count] = b; word_count++; end
            end
            CMD_APPEND_PAT: begin
                if (pat_len >= MAX_LEN) r.status = ST_FULL;
                else begin pat_mem[pat_len] = b; pat_len++; end
            end
            CMD_APPEND_REP: begin
                if (rep_len >= MAX_LEN) r.status = ST_FULL;
                else begin rep_mem[rep_len] = b; rep_len++; end
            end
            CMD_CLEAR_PR: begin
                pat_len = 0;
                rep_len = 0;
            end
            CMD_CLEAR_WORD: word_count = 0;
            CMD_RUN: r.status = replace_all();
            CMD_READ: if (int'(idx) < word_count) r.rbyte = word_mem[idx];
            default: ;
        endcase
        r.wlen = word_count[7:0];
        return r;
    endfunction

    assign o_pending = expected_results.size();
    assign o_errors  = error_count;

    // Predict on each input transaction, compare on each output transaction.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            word_count = 0;
            pat_len    = 0;
            rep_len    = 0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_command(t_cmd'(i_s_tuser),
                                           i_s_tdata[7:0], i_s_tdata[14:8]));
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[17:0]);
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.wlen !== want.wlen)
                        report_mismatch("word_length", got.wlen, want.wlen);
                    if (got.rbyte !== want.rbyte)
                        report_mismatch("read_byte", got.rbyte, want.rbyte);
                    if (i_m_tdata[23:18] !== '0)
                        report_mismatch("pad bits", i_m_tdata[23:18], 0);
                end
            end
        end
    end

endmodule

@@ dv/substring_replace_all_tb.sv @@
// Top of the substring replace testbench: clock, reset, stimulus and verdict.
module substring_replace_all_tb;
    import ssr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    errors;
    int                    pending;

    substring_replace_all i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    substring_replace_all_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Mostly short gaps, now and then a long one, often none.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) m_tready <= 0;
        else begin
            n = gap_len();
            m_tready <= (n == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // Sends one command transaction, then idles for a random gap.
    task automatic send_command(input t_cmd cmd, input logic [7:0] b, input logic [6:0] idx);
        int n;
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, idx, b};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        n = gap_len();
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic load_bytes(input t_cmd cmd, input int count, input int alphabet);
        for (int i = 0; i < count; i++)
            send_command(cmd, 8'($urandom_range(0, alphabet - 1)), 7'($urandom));
    endtask

    task automatic read_back(input int count);
        for (int i = 0; i < count; i++)
            send_command(CMD_READ, 8'($urandom), 7'($urandom_range(0, 127)));
    endtask

    initial begin
        int sent, plen, rlen, wlen, alpha;
        i_rst_n  <= 0;
        s_tvalid <= 0;
        s_tdata  <= '0;
        s_tuser  <= CMD_NOP;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty run, extremes, a simple replacement, unused code, full store.
        send_command(CMD_RUN, 8'h00, 7'h00);
        send_command(CMD_READ, 8'hFF, 7'h7F);
        send_command(CMD_APPEND_WORD, 8'h00, 7'h7F);
        send_command(CMD_APPEND_WORD, 8'hFF, 7'h00);
        send_command(CMD_APPEND_WORD, 8'h00, 7'h55);
        send_command(CMD_APPEND_PAT, 8'hFF, 7'h2A);
        send_command(CMD_APPEND_REP, 8'hA5, 7'h00);
        send_command(CMD_APPEND_REP, 8'h5A, 7'h00);
        send_command(CMD_RUN, 8'h00, 7'h00);
        send_command(CMD_READ, 8'h00, 7'h01);
        send_command(CMD_READ, 8'h00, 7'h02);
        send_command(CMD_READ, 8'h00, 7'h04);
        send_command(CMD_NOP, 8'hFF, 7'h7F);
        send_command(CMD_CLEAR_PR, 8'h00, 7'h00);
        send_command(CMD_CLEAR_WORD, 8'h00, 7'h00);
        // Fill the word to capacity with the same byte, then one more is refused.
        load_bytes(CMD_APPEND_WORD, 129, 1);
        send_command(CMD_READ, 8'h00, 7'h7F);
        // A one-byte pattern grown to two bytes overflows at once.
        send_command(CMD_APPEND_PAT, 8'h00, 7'h00);
        load_bytes(CMD_APPEND_REP, 2, 1);
        send_command(CMD_RUN, 8'h00, 7'h00);
        // Fill pattern and replacement stores to capacity as well.
        send_command(CMD_CLEAR_PR, 8'h00, 7'h00);
        load_bytes(CMD_APPEND_PAT, 129, 256);
        load_bytes(CMD_APPEND_REP, 129, 256);
        send_command(CMD_RUN, 8'h00, 7'h00);
        send_command(CMD_CLEAR_PR, 8'h00, 7'h00);
        send_command(CMD_CLEAR_WORD, 8'h00, 7'h00);

        // Random: mostly well-formed load-run-read sequences on small alphabets.
        sent = 0;
        while (sent < 700) begin
            alpha = $urandom_range(1, 3);
            wlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 128)
                                                : $urandom_range(0, 20);
            plen  = $urandom_range(0, 3);
            rlen  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(0, 4);
            send_command(CMD_CLEAR_WORD, 8'($urandom), 7'($urandom));
            send_command(CMD_CLEAR_PR, 8'($urandom), 7'($urandom));
            load_bytes(CMD_APPEND_WORD, wlen, alpha);
            load_bytes(CMD_APPEND_PAT, plen, alpha);
            load_bytes(CMD_APPEND_REP, rlen, ($urandom_range(0, 1) != 0) ? alpha : 256);
            send_command(CMD_RUN, 8'($urandom), 7'($urandom));
            read_back($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0)
                send_command(t_cmd'($urandom_range(0, 7)), 8'($urandom), 7'($urandom));
            if ($urandom_range(0, 2) == 0)
                send_command(CMD_RUN, 8'($urandom), 7'($urandom));
            sent += wlen + plen + rlen + 6;
        end
        s_tvalid <= 0;

        // Let the checker record the last transaction before draining.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("PASS substring_replace_all");
        else
            $display("FAIL substring_replace_all");
        $finish;
    end

    // Run limit well above the slowest correct run.
    initial begin
        #200ms;
        $display("FAIL substring_replace_all");
        $finish;
    end
endmodule

@@ substring_replace_all.f @@
sv/ssr_pkg.sv
sv/ssr_ram.sv
sv/ssr_ctrl.sv
sv/substring_replace_all.sv
dv/substring_replace_all_checker.sv
dv/substring_replace_all_tb.sv
